>>> hdl/oit_pkg.sv
// ----------------------------------------------------------------------------
// oit_pkg
// shared constants, the ring control type and the helper function of the orbital integral engine
// ----------------------------------------------------------------------------
package oit_pkg;

  localparam int MaxOrb = 64;
  localparam int IdxW   = $clog2(MaxOrb);
  localparam int AddrW  = 2 * IdxW;
  localparam int CellW  = 48;

  localparam logic [1:0] ReqLoadKernel = 2'd0;
  localparam logic [1:0] ReqLoadCoef   = 2'd1;
  localparam logic [1:0] ReqQuery      = 2'd2;
  localparam logic [1:0] ReqRestart    = 2'd3;

  typedef struct packed {
    logic            en;
    logic            load;
    logic [IdxW-1:0] tail;
  } ring_ctrl_t;

  // triangular pair index max(a,b)(max(a,b)+1)/2 + min(a,b)
  function automatic logic [31:0] tri_pair(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] p;
    hi = (a > b) ? 32'(a) : 32'(b);
    lo = (a > b) ? 32'(b) : 32'(a);
    p  = hi * (hi + 32'd1);
    return (p >> 1) + lo;
  endfunction

endpackage

>>> hdl/oit_req_if.sv
// ----------------------------------------------------------------------------
// oit_req_if
// request channel: loads, queries and restarts
// ----------------------------------------------------------------------------
interface oit_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [5:0]         row;
  logic [5:0]         col;
  logic signed [31:0] load_value;
  logic [5:0]         orb_i;
  logic [5:0]         orb_j;
  logic [5:0]         orb_k;
  logic [5:0]         orb_l;

  modport source (output valid, req_type, row, col, load_value, orb_i, orb_j, orb_k, orb_l,
                  input ready);
  modport sink (input valid, req_type, row, col, load_value, orb_i, orb_j, orb_k, orb_l,
                output ready);
endinterface

>>> hdl/oit_res_if.sv
// ----------------------------------------------------------------------------
// oit_res_if
// result channel: kept integrals
// ----------------------------------------------------------------------------
interface oit_res_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] integral_value;
  logic [21:0]        packed_index;
  logic [23:0]        kept_ordinal;

  modport source (output valid, integral_value, packed_index, kept_ordinal, input ready);
  modport sink (input valid, integral_value, packed_index, kept_ordinal, output ready);
endinterface

>>> hdl/oit_ram.sv
// ----------------------------------------------------------------------------
// oit_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module oit_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hdl/oit_cell.sv
// ----------------------------------------------------------------------------
// oit_cell
// one ring cell: takes its neighbour's value, or the feed when it is the tail
// ----------------------------------------------------------------------------
module oit_cell (
  input  logic                      clk_i,
  input  oit_pkg::ring_ctrl_t       ctrl_i,
  input  logic                      is_tail_i,
  input  logic [oit_pkg::CellW-1:0] feed_i,
  input  logic [oit_pkg::CellW-1:0] next_i,
  output logic [oit_pkg::CellW-1:0] val_o
);
  import oit_pkg::*;

  logic [CellW-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      val_q <= is_tail_i ? feed_i : next_i;
    end
  end

  assign val_o = val_q;
endmodule

>>> hdl/oit_ring.sv
// ----------------------------------------------------------------------------
// oit_ring
// row of cells closed into a ring of active length; loads at the tail
// ----------------------------------------------------------------------------
module oit_ring (
  input  logic                      clk_i,
  input  oit_pkg::ring_ctrl_t       ctrl_i,
  input  logic [oit_pkg::CellW-1:0] data_i,
  output logic [oit_pkg::CellW-1:0] head_o
);
  import oit_pkg::*;

  logic [CellW-1:0] cell_val [MaxOrb];
  logic [CellW-1:0] feed;

  assign feed   = ctrl_i.load ? data_i : cell_val[0];
  assign head_o = cell_val[0];

  for (genvar m = 0; m < MaxOrb; m++) begin : g_cell
    logic [CellW-1:0] nxt;
    if (m == MaxOrb - 1) begin : g_last
      assign nxt = feed;
    end else begin : g_mid
      assign nxt = cell_val[m+1];
    end
    oit_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl_i),
      .is_tail_i (ctrl_i.tail == IdxW'(m)),
      .feed_i    (feed),
      .next_i    (nxt),
      .val_o     (cell_val[m])
    );
  end
endmodule

>>> hdl/orbital_integral_transform_top.sv
// ----------------------------------------------------------------------------
// orbital_integral_transform_top
// four-index orbital integral engine over a kernel store and a coefficient store
// ----------------------------------------------------------------------------
// loads and restarts stay in idle; a query with the pair kept goes straight to the query
// phase; a query with a new pair first builds the density and the kernel product,
// with the single kernel multiply-accumulate walking the density ring
// one query at a time; a kept result waits in an output register
// async active-low reset resets control and counters, not the datapath or the stores
module orbital_integral_transform_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  oit_req_if.sink     req,
  oit_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import oit_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDens = 3'd1;
  localparam logic [2:0] SKern = 3'd2;
  localparam logic [2:0] SQry  = 3'd3;
  localparam logic [2:0] SFin  = 3'd4;
  localparam logic [2:0] SEmit = 3'd5;

  localparam logic RegBasis = 1'b0;
  localparam logic RegThr   = 1'b1;

  logic [2:0]  state_q, state_d;
  logic [6:0]  basis_q;
  logic [62:0] thr_q;
  logic [6:0]  n_act;
  logic [IdxW-1:0] nm1;

  logic in_acc, cfg_wr, load_ok, qry_ok, slot_free;
  logic [AddrW-1:0] load_addr;

  logic [IdxW-1:0] oi_q, oj_q, ok_q, ol_q;
  logic [11:0] pair_q;
  logic        pv_q;
  logic [15:0] ij_q, kl_q;
  logic [23:0] kept_q;

  logic            iss_q;
  logic [IdxW-1:0] cnt_q, cnt2_q;
  logic            last_m, last_r;

  logic [31:0] k_rd, a_rd, b_rd;
  logic [AddrW-1:0] k_ra, a_ra, b_ra;

  // density build
  logic               dv1_q, dv2_q;
  logic signed [63:0] dp_q;
  logic signed [63:0] d_rnd;

  // kernel product
  logic               kv1_q, kv2_q, kl1_q, kl2_q;
  logic signed [31:0] dh_q;
  logic signed [63:0] kp_q;
  logic signed [63:0] k_term;
  logic signed [47:0] kacc_q, kacc_n;

  // query
  logic               qv1_q, qv2_q, qv3_q, qv4_q;
  logic signed [47:0] g_q;
  logic signed [55:0] ph_q;
  logic signed [56:0] pl_q;
  logic signed [31:0] cl2_q, cl3_q;
  logic signed [63:0] t_q;
  logic signed [65:0] qh_q;
  logic signed [62:0] ql_q;
  logic signed [71:0] acc_q;

  logic signed [63:0] val_q, val_sat;
  logic               keep_q;
  logic [21:0]        idx_q;
  logic [63:0]        mag;

  logic               rv_q;
  logic signed [63:0] oval_q;
  logic [21:0]        oidx_q;
  logic [23:0]        oord_q;

  logic [CellW-1:0] dens_head, g_head, dens_data;
  ring_ctrl_t dens_ctrl, g_ctrl;

  assign n_act = (basis_q == 7'd0) ? 7'd1 :
                 ((32'(basis_q) > MaxOrb) ? 7'(MaxOrb) : basis_q);
  assign nm1   = IdxW'(n_act - 7'd1);

  assign pready  = 1'b1;
  assign prdata  = (paddr[3] == RegThr) ? {1'b0, thr_q} : {57'd0, basis_q};
  assign cfg_wr  = psel & penable & pwrite;

  assign req.ready = (state_q == SIdle);
  assign in_acc    = req.valid & req.ready;
  assign load_ok   = (32'(req.row) < MaxOrb) && (32'(req.col) < MaxOrb);
  assign load_addr = {IdxW'(req.row), IdxW'(req.col)};
  assign qry_ok    = (32'(req.orb_i) < 32'(n_act)) && (32'(req.orb_j) < 32'(n_act)) &&
                     (32'(req.orb_k) < 32'(n_act)) && (32'(req.orb_l) < 32'(n_act));
  assign slot_free = !rv_q || res.ready;

  assign last_m = (cnt_q == nm1);
  assign last_r = (cnt2_q == nm1);

  // stores
  assign k_ra = {cnt2_q, cnt_q};
  assign a_ra = (state_q == SQry) ? {cnt_q, ok_q} : {cnt_q, oi_q};
  assign b_ra = (state_q == SQry) ? {cnt_q, ol_q} : {cnt_q, oj_q};

  oit_ram #(.Width(32), .Depth(MaxOrb * MaxOrb)) u_kernel (
    .clk_i (clk_i), .we_i (in_acc && req.req_type == ReqLoadKernel && load_ok),
    .waddr_i (load_addr), .wdata_i (req.load_value), .raddr_i (k_ra), .rdata_o (k_rd)
  );
  oit_ram #(.Width(32), .Depth(MaxOrb * MaxOrb)) u_coef_a (
    .clk_i (clk_i), .we_i (in_acc && req.req_type == ReqLoadCoef && load_ok),
    .waddr_i (load_addr), .wdata_i (req.load_value), .raddr_i (a_ra), .rdata_o (a_rd)
  );
  oit_ram #(.Width(32), .Depth(MaxOrb * MaxOrb)) u_coef_b (
    .clk_i (clk_i), .we_i (in_acc && req.req_type == ReqLoadCoef && load_ok),
    .waddr_i (load_addr), .wdata_i (req.load_value), .raddr_i (b_ra), .rdata_o (b_rd)
  );

  // rings
  assign d_rnd     = (dp_q + 64'sd2147483648) >>> 32;
  assign dens_data = CellW'(d_rnd);
  assign dens_ctrl = '{en: dv2_q | (state_q == SKern && iss_q), load: dv2_q, tail: nm1};

  assign k_term = (kp_q + 64'sd33554432) >>> 26;
  assign kacc_n = kacc_q + 48'(k_term);
  assign g_ctrl = '{en: (kv2_q && kl2_q) | (state_q == SQry && iss_q),
                    load: kv2_q && kl2_q, tail: nm1};

  oit_ring u_dens (.clk_i (clk_i), .ctrl_i (dens_ctrl), .data_i (dens_data),
                   .head_o (dens_head));
  oit_ring u_gvec (.clk_i (clk_i), .ctrl_i (g_ctrl), .data_i (kacc_n), .head_o (g_head));

  // datapath
  always_ff @(posedge clk_i) begin
    dh_q <= dens_head[31:0];
    g_q  <= g_head;
    if (dv1_q) begin
      dp_q <= $signed(a_rd) * $signed(b_rd);
    end
    if (kv1_q) begin
      kp_q <= $signed(k_rd) * dh_q;
    end
    if (qv1_q) begin
      ph_q  <= $signed(g_q[47:24]) * $signed(a_rd);
      pl_q  <= $signed({1'b0, g_q[23:0]}) * $signed(a_rd);
      cl2_q <= b_rd;
    end
    if (qv2_q) begin
      t_q   <= (64'(ph_q) <<< 10) + 64'((pl_q + 57'sd8192) >>> 14);
      cl3_q <= cl2_q;
    end
    if (qv3_q) begin
      qh_q <= $signed(t_q[63:30]) * cl3_q;
      ql_q <= $signed({1'b0, t_q[29:0]}) * cl3_q;
    end
  end

  assign val_sat = (acc_q[71:63] == 9'd0 || acc_q[71:63] == 9'h1FF) ? acc_q[63:0] :
                   (acc_q[71] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});
  assign mag     = val_sat[63] ? (64'd0 - val_sat) : val_sat;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (in_acc && req.req_type == ReqQuery && qry_ok) begin
        state_d = (pv_q && pair_q == {req.orb_i, req.orb_j}) ? SQry : SDens;
      end
      SDens: if (!iss_q && !dv1_q && !dv2_q) state_d = SKern;
      SKern: if (!iss_q && !kv1_q && !kv2_q) state_d = SQry;
      SQry:  if (!iss_q && !qv1_q && !qv2_q && !qv3_q && !qv4_q) state_d = SFin;
      SFin:  state_d = SEmit;
      SEmit: if (!keep_q || slot_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      basis_q <= 7'(MaxOrb);
      thr_q   <= '0;
      pv_q    <= 1'b0;
      pair_q  <= '0;
      kept_q  <= '0;
      iss_q   <= 1'b0;
      cnt_q   <= '0;
      cnt2_q  <= '0;
      dv1_q   <= 1'b0;
      dv2_q   <= 1'b0;
      kv1_q   <= 1'b0;
      kv2_q   <= 1'b0;
      kl1_q   <= 1'b0;
      kl2_q   <= 1'b0;
      qv1_q   <= 1'b0;
      qv2_q   <= 1'b0;
      qv3_q   <= 1'b0;
      qv4_q   <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      dv1_q   <= (state_q == SDens) && iss_q;
      dv2_q   <= dv1_q;
      kv1_q   <= (state_q == SKern) && iss_q;
      kl1_q   <= last_m;
      kv2_q   <= kv1_q;
      kl2_q   <= kl1_q;
      qv1_q   <= (state_q == SQry) && iss_q;
      qv2_q   <= qv1_q;
      qv3_q   <= qv2_q;
      qv4_q   <= qv3_q;

      if (state_q == SEmit && keep_q && slot_free) begin
        rv_q <= 1'b1;
      end else if (res.ready) begin
        rv_q <= 1'b0;
      end

      if (cfg_wr) begin
        if (paddr[3] == RegBasis) begin
          basis_q <= pwdata[6:0];
          pv_q    <= 1'b0;
        end else begin
          thr_q <= pwdata[62:0];
        end
      end

      unique case (state_q)
        SIdle: if (in_acc) begin
          if ((req.req_type == ReqLoadKernel || req.req_type == ReqLoadCoef) && load_ok) begin
            pv_q <= 1'b0;
          end
          if (req.req_type == ReqRestart) begin
            kept_q <= '0;
          end
          if (req.req_type == ReqQuery && qry_ok) begin
            pv_q   <= 1'b1;
            pair_q <= {req.orb_i, req.orb_j};
            iss_q  <= 1'b1;
            cnt_q  <= '0;
            cnt2_q <= '0;
          end
        end
        SDens: begin
          if (iss_q) begin
            cnt_q <= cnt_q + 1'b1;
            if (last_m) iss_q <= 1'b0;
          end else if (!dv1_q && !dv2_q) begin
            iss_q  <= 1'b1;
            cnt_q  <= '0;
            cnt2_q <= '0;
          end
        end
        SKern: begin
          if (iss_q) begin
            cnt_q <= last_m ? '0 : cnt_q + 1'b1;
            if (last_m) begin
              cnt2_q <= cnt2_q + 1'b1;
              if (last_r) iss_q <= 1'b0;
            end
          end else if (!kv1_q && !kv2_q) begin
            iss_q <= 1'b1;
            cnt_q <= '0;
          end
        end
        SQry: if (iss_q) begin
          cnt_q <= cnt_q + 1'b1;
          if (last_m) iss_q <= 1'b0;
        end
        SFin: ;
        SEmit: if (keep_q && slot_free) begin
          kept_q <= kept_q + 24'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && req.req_type == ReqQuery) begin
      oi_q <= IdxW'(req.orb_i);
      oj_q <= IdxW'(req.orb_j);
      ok_q <= IdxW'(req.orb_k);
      ol_q <= IdxW'(req.orb_l);
      ij_q <= 16'(tri_pair(16'(req.orb_i), 16'(req.orb_j)));
      kl_q <= 16'(tri_pair(16'(req.orb_k), 16'(req.orb_l)));
      acc_q <= '0;
    end else if (qv4_q) begin
      acc_q <= acc_q + 72'(qh_q) + 72'((ql_q + 63'sd536870912) >>> 30);
    end
    if (state_q == SDens) begin
      kacc_q <= '0;
    end else if (kv2_q) begin
      kacc_q <= kl2_q ? '0 : kacc_n;
    end
    if (state_q == SFin) begin
      val_q <= val_sat;
      idx_q <= 22'(tri_pair(ij_q, kl_q));
    end
    if (state_q == SFin) begin
      keep_q <= (mag > {1'b0, thr_q});
    end else if (state_q != SEmit) begin
      keep_q <= 1'b0;
    end
    if (state_q == SEmit && keep_q && slot_free) begin
      oval_q <= val_q;
      oidx_q <= idx_q;
      oord_q <= kept_q;
    end
  end

  assign res.valid          = rv_q;
  assign res.integral_value = oval_q;
  assign res.packed_index   = oidx_q;
  assign res.kept_ordinal   = oord_q;

`ifndef SYNTH
  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SEmit && keep_q && rv_q && !res.ready |=> state_q == SEmit)
    else $error("kept integral left before the output register was free");
  a_qry_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qv4_q |-> state_q == SQry)
    else $error("query pipeline active outside a query");
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && load_ok && (req.req_type == ReqLoadKernel || req.req_type == ReqLoadCoef)
    |=> !pv_q)
    else $error("pair cache still valid after a load");
  a_kept_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SEmit && keep_q && slot_free |=> kept_q == $past(kept_q) + 24'd1)
    else $error("kept counter did not advance on a kept integral");
`endif
endmodule
